>>> hdl/pba_pkg.sv
// shared types and constants for the pad button autorepeat block
package pba_pkg;

  // number of controller ports kept in the state arrays
  localparam int Ports = 2;

  localparam int WordW = 24;
  localparam int BtnW  = 16;
  localparam int AxisW = 8;
  localparam int CntW  = 5;
  localparam int LvlW  = 7;

  // controller kind codes
  localparam logic [1:0] KindNone    = 2'd0;
  localparam logic [1:0] KindDigital = 2'd1;
  localparam logic [1:0] KindAnalog  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgNtscMode  = 2'd0;
  localparam logic [1:0] CfgPort0Kind = 2'd1;
  localparam logic [1:0] CfgPort1Kind = 2'd2;

  // stick thresholds
  localparam logic [AxisW-1:0] StickHi = 8'hbf;
  localparam logic [AxisW-1:0] StickLo = 8'h40;

  // repeat timing
  localparam logic [CntW-1:0] FirstNtsc    = 5'd25;
  localparam logic [CntW-1:0] FirstPal     = 5'd21;
  localparam logic [CntW-1:0] EarlyNtsc    = 5'd20;
  localparam logic [CntW-1:0] EarlyPal     = 5'd17;
  localparam logic [CntW-1:0] LateNtsc     = 5'd23;
  localparam logic [CntW-1:0] LatePal      = 5'd19;
  localparam logic [CntW-1:0] EarlyRepeats = 5'd20;
  localparam logic [CntW-1:0] HoldMax      = 5'd31;

  // stick direction bits in the pad word
  localparam logic [WordW-1:0] BitRxHi = 24'h080000;
  localparam logic [WordW-1:0] BitRxLo = 24'h040000;
  localparam logic [WordW-1:0] BitRyLo = 24'h010000;
  localparam logic [WordW-1:0] BitRyHi = 24'h020000;
  localparam logic [WordW-1:0] BitLxHi = 24'h800000;
  localparam logic [WordW-1:0] BitLxLo = 24'h400000;
  localparam logic [WordW-1:0] BitLyLo = 24'h100000;
  localparam logic [WordW-1:0] BitLyHi = 24'h200000;

  // one poll beat
  typedef struct packed {
    logic             port_index;
    logic             link_ready;
    logic             read_ok;
    logic [BtnW-1:0]  buttons_raw;
    logic [AxisW-1:0] right_x;
    logic [AxisW-1:0] right_y;
    logic [AxisW-1:0] left_x;
    logic [AxisW-1:0] left_y;
  } poll_t;

  // one result beat
  typedef struct packed {
    logic [WordW-1:0] port_pressed;
    logic [WordW-1:0] all_pressed;
    logic [WordW-1:0] port_held;
    logic [LvlW-1:0]  stick_magnitude;
    logic             poll_ok;
  } res_t;

  // configuration seen by the core
  typedef struct packed {
    logic       ntsc_mode;
    logic [1:0] port0_kind;
    logic [1:0] port1_kind;
  } cfg_t;

endpackage

>>> hdl/pad_button_autorepeat.sv
// top level of the pad button autorepeat block
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall   | port_index .. left_y
//  out_    | output    | out_valid / out_stall | port_pressed .. poll_ok
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// a beat lands in the input register, then combinational logic updates the
// port state and loads the result register.
// one beat per cycle is sustained while out_stall is low; the per-port next state is combinational.
// synchronous active-low reset clears the valid flags, port state and port kinds; ntsc_mode resets to 1.
// a stalled result holds; one more beat waits in the input register.
module pad_button_autorepeat import pba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_port_index,
  input  logic             in_link_ready,
  input  logic             in_read_ok,
  input  logic [BtnW-1:0]  in_buttons_raw,
  input  logic [AxisW-1:0] in_right_x,
  input  logic [AxisW-1:0] in_right_y,
  input  logic [AxisW-1:0] in_left_x,
  input  logic [AxisW-1:0] in_left_y,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WordW-1:0] out_port_pressed,
  output logic [WordW-1:0] out_all_pressed,
  output logic [WordW-1:0] out_port_held,
  output logic [LvlW-1:0]  out_stick_magnitude,
  output logic             out_poll_ok,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [1:0]       cfg_wdata
);

  poll_t in_item;
  poll_t item;
  logic  item_vld;
  logic  out_free;
  logic  go;
  res_t  res;
  res_t  res_r;
  logic  out_vld_r, out_vld_nxt;
  cfg_t  cfg_r;

  assign in_item = '{port_index:  in_port_index,
                     link_ready:  in_link_ready,
                     read_ok:     in_read_ok,
                     buttons_raw: in_buttons_raw,
                     right_x:     in_right_x,
                     right_y:     in_right_y,
                     left_x:      in_left_x,
                     left_y:      in_left_y};

  // result register can take a beat when empty or being drained
  assign out_free = !out_vld_r || !out_stall;
  assign go       = item_vld && out_free;

  pba_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (out_free),
    .vld      (item_vld),
    .item     (item)
  );

  pba_poll_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ntsc_mode  <= 1'b1;
      cfg_r.port0_kind <= KindNone;
      cfg_r.port1_kind <= KindNone;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgNtscMode:  cfg_r.ntsc_mode  <= cfg_wdata[0];
        CfgPort0Kind: cfg_r.port0_kind <= cfg_wdata;
        CfgPort1Kind: cfg_r.port1_kind <= cfg_wdata;
        default:      cfg_r            <= cfg_r;
      endcase
    end
  end

  // result register valid
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (go) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_port_pressed    = res_r.port_pressed;
  assign out_all_pressed     = res_r.all_pressed;
  assign out_port_held       = res_r.port_held;
  assign out_stick_magnitude = res_r.stick_magnitude;
  assign out_poll_ok         = res_r.poll_ok;

endmodule

>>> hdl/pba_in_reg.sv
// input register stage for poll beats
module pba_in_reg import pba_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  poll_t in_item,
  input  logic  advance,
  output logic  vld,
  output poll_t item
);

  logic  vld_r, vld_nxt;
  poll_t item_r;
  logic  take;

  // hold off only when a beat sits here and cannot move on
  assign in_stall = vld_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

>>> hdl/pba_poll_core.sv
// per-port press detection, stick scan and autorepeat state
module pba_poll_core import pba_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  go,
  input  poll_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [WordW-1:0] held_r  [Ports];
  logic [WordW-1:0] prev_r  [Ports];
  logic [WordW-1:0] fresh_r [Ports];
  logic [CntW-1:0]  hold_r  [Ports];
  logic [CntW-1:0]  rep_r   [Ports];
  logic             phase_r;
  logic [LvlW-1:0]  level_r;

  logic [WordW-1:0] held_nxt  [Ports];
  logic [WordW-1:0] prev_nxt  [Ports];
  logic [WordW-1:0] fresh_nxt [Ports];
  logic [CntW-1:0]  hold_nxt  [Ports];
  logic [CntW-1:0]  rep_nxt   [Ports];
  logic             phase_nxt;
  logic [LvlW-1:0]  level_nxt;

  logic             p;
  logic [1:0]       kind;
  logic             rd_good;
  logic             scan;
  logic [WordW-1:0] word;
  logic [WordW-1:0] btn_word;
  logic [CntW-1:0]  hold_inc;
  logic [CntW-1:0]  first;
  logic             rx_hi, rx_lo, ry_hi, ry_lo, lx_hi, lx_lo, ly_hi, ly_lo;
  logic [AxisW-1:0] d_rx_hi, d_rx_lo, d_ry_hi, d_ry_lo;
  logic [AxisW-1:0] d_lx_hi, d_lx_lo, d_ly_hi, d_ly_lo;

  assign p       = item.port_index;
  assign kind    = item.port_index ? cfg.port1_kind : cfg.port0_kind;
  assign rd_good = item.link_ready && item.read_ok;
  assign scan    = (kind == KindAnalog) && phase_r;
  assign first   = cfg.ntsc_mode ? FirstNtsc : FirstPal;

  // stick threshold compares and distances
  assign rx_hi = item.right_x >= StickHi;
  assign rx_lo = item.right_x <= StickLo;
  assign ry_hi = item.right_y >= StickHi;
  assign ry_lo = item.right_y <= StickLo;
  assign lx_hi = item.left_x  >= StickHi;
  assign lx_lo = item.left_x  <= StickLo;
  assign ly_hi = item.left_y  >= StickHi;
  assign ly_lo = item.left_y  <= StickLo;

  assign d_rx_hi = item.right_x - StickHi;
  assign d_rx_lo = StickLo - item.right_x;
  assign d_ry_hi = item.right_y - StickHi;
  assign d_ry_lo = StickLo - item.right_y;
  assign d_lx_hi = item.left_x  - StickHi;
  assign d_lx_lo = StickLo - item.left_x;
  assign d_ly_hi = item.left_y  - StickHi;
  assign d_ly_lo = StickLo - item.left_y;

  assign btn_word = {{(WordW-BtnW){1'b0}}, ~item.buttons_raw};

  // pad word and stick level for this poll
  always_comb begin
    word      = btn_word;
    level_nxt = level_r;
    phase_nxt = phase_r;
    if (go && rd_good && kind == KindAnalog) begin
      phase_nxt = ~phase_r;
    end
    if (go && rd_good && scan) begin
      level_nxt = '0;
      if (rx_hi) begin
        word = BitRxHi; level_nxt = d_rx_hi[LvlW-1:0];
      end else if (rx_lo) begin
        word = BitRxLo; level_nxt = d_rx_lo[LvlW-1:0];
      end else if (ry_lo) begin
        word = BitRyLo; level_nxt = d_ry_lo[LvlW-1:0];
      end else if (ry_hi) begin
        word = BitRyHi; level_nxt = d_ry_hi[LvlW-1:0];
      end else if (lx_hi) begin
        word = BitLxHi; level_nxt = d_lx_hi[LvlW-1:0];
      end else if (lx_lo) begin
        word = BitLxLo; level_nxt = d_lx_lo[LvlW-1:0];
      end else if (ly_lo) begin
        word = BitLyLo; level_nxt = d_ly_lo[LvlW-1:0];
      end else if (ly_hi) begin
        word = BitLyHi; level_nxt = d_ly_hi[LvlW-1:0];
      end
    end
  end

  assign hold_inc = (hold_r[p] < HoldMax) ? hold_r[p] + 5'd1 : hold_r[p];

  // press detection and repeat timing for the polled port
  always_comb begin
    held_nxt  = held_r;
    prev_nxt  = prev_r;
    fresh_nxt = fresh_r;
    hold_nxt  = hold_r;
    rep_nxt   = rep_r;
    if (go) begin
      if (!item.link_ready) begin
        fresh_nxt[p] = '0;
      end else if (item.read_ok) begin
        fresh_nxt[p] = word & ~prev_r[p];
        if (prev_r[p] == word) begin
          hold_nxt[p] = hold_inc;
          if (hold_inc >= first) begin
            fresh_nxt[p] = word;
            if (rep_r[p] < EarlyRepeats) begin
              hold_nxt[p] = cfg.ntsc_mode ? EarlyNtsc : EarlyPal;
              rep_nxt[p]  = rep_r[p] + 5'd1;
            end else begin
              hold_nxt[p] = cfg.ntsc_mode ? LateNtsc : LatePal;
            end
          end
        end else begin
          hold_nxt[p] = '0;
          rep_nxt[p]  = '0;
          prev_nxt[p] = word;
        end
        held_nxt[p] = word;
      end
    end
  end

  // result from the updated state
  always_comb begin
    res.all_pressed = '0;
    for (int i = 0; i < Ports; i++) begin
      res.all_pressed = res.all_pressed | fresh_nxt[i];
    end
    res.port_pressed    = fresh_nxt[p];
    res.port_held       = held_nxt[p];
    res.stick_magnitude = level_nxt;
    res.poll_ok         = rd_good;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Ports; i++) begin
        held_r[i]  <= '0;
        prev_r[i]  <= '0;
        fresh_r[i] <= '0;
        hold_r[i]  <= '0;
        rep_r[i]   <= '0;
      end
      phase_r <= 1'b0;
      level_r <= '0;
    end else begin
      held_r  <= held_nxt;
      prev_r  <= prev_nxt;
      fresh_r <= fresh_nxt;
      hold_r  <= hold_nxt;
      rep_r   <= rep_nxt;
      phase_r <= phase_nxt;
      level_r <= level_nxt;
    end
  end

  // early repeat count never passes its cap
  a_rep_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r[0] <= EarlyRepeats && rep_r[1] <= EarlyRepeats)
    else $error("repeat count above cap");

  // a dead link clears that port's fresh presses
  a_link_clear: assert property (@(posedge clk) disable iff (!rst_n)
    go && !item.link_ready |=> fresh_r[$past(item.port_index)] == '0)
    else $error("fresh presses kept on dead link");

  // held words move only on a good read
  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(go && rd_good) |=> $stable(held_r[0]) && $stable(held_r[1]))
    else $error("held word changed without a good read");

  // the scan phase toggles only on a good read of an analog port
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !(go && rd_good && kind == KindAnalog) |=> $stable(phase_r))
    else $error("stick phase moved unexpectedly");

endmodule
